### sv/integer_matrix_multiply_macros.svh
// Assertion macros used by the RTL controller
`ifndef INTEGER_MATRIX_MULTIPLY_MACROS_SVH
`define INTEGER_MATRIX_MULTIPLY_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define IMM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("imm assertion failed");
// next-cycle implication
`define IMM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("imm assertion failed");
`else
`define IMM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define IMM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### sv/imm_pkg.sv
package imm_pkg;

    localparam int DIM_DEF   = 64;
    localparam int IDX_W     = 6;
    localparam int DATA_W    = 32;
    localparam int S_FIELD_W = 2 * IDX_W + 3 * DATA_W;
    localparam int S_TDATA_W = ((S_FIELD_W + 7) / 8) * 8;
    localparam int M_FIELD_W = DATA_W + 2 * IDX_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic write;     // store the accepted element
        logic start;     // latch a read request
        logic issue;     // fetch one A/B pair
        logic load_out;  // move the sum into the output register
    } cmd_t;

    typedef struct packed {
        logic req_inside;  // incoming row/col lie inside the matrix
        logic issue_last;  // final pair being fetched
        logic pipe_empty;  // no fetch or product in flight
    } sts_t;

endpackage

### sv/imm_ram.sv
module imm_ram #(
    parameter int WIDTH = imm_pkg::DATA_W,
    parameter int DEPTH = imm_pkg::DIM_DEF * imm_pkg::DIM_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/imm_datapath.sv
module imm_datapath #(
    parameter int DIM = imm_pkg::DIM_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [imm_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic [imm_pkg::M_TDATA_W-1:0]  m_tdata,
    input  imm_pkg::cmd_t                  cmd,
    output imm_pkg::sts_t                  sts
);
    import imm_pkg::*;

    localparam int CELLS = DIM * DIM;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int IW    = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int M_PAD = M_TDATA_W - M_FIELD_W;

    function automatic logic [AW-1:0] cell_addr(input logic [31:0] r, input logic [31:0] c);
        logic [31:0] a;
        a = r * 32'(DIM) + c;
        return a[AW-1:0];
    endfunction

    logic [IDX_W-1:0]  in_row, in_col;
    logic [DATA_W-1:0] in_left, in_right, in_start;
    logic [AW-1:0]     wr_addr;
    logic              wr_en;

    assign in_row   = s_tdata[IDX_W-1:0];
    assign in_col   = s_tdata[2*IDX_W-1:IDX_W];
    assign in_left  = s_tdata[2*IDX_W +: DATA_W];
    assign in_right = s_tdata[2*IDX_W+DATA_W +: DATA_W];
    assign in_start = s_tdata[2*IDX_W+2*DATA_W +: DATA_W];

    assign sts.req_inside = (32'(in_row) < 32'(DIM)) && (32'(in_col) < 32'(DIM));
    assign wr_addr        = cell_addr(32'(in_row), 32'(in_col));
    assign wr_en          = cmd.write && sts.req_inside;

    logic [IDX_W-1:0]  row_reg, row_next, col_reg, col_next;
    logic              inside_reg, inside_next;
    logic [IW-1:0]     k_reg, k_next;
    logic              rd_vld_reg, first_vld_reg, mul_vld_reg;
    logic [DATA_W-1:0] prod_reg, prod_next, acc_reg, acc_next;
    logic [M_TDATA_W-1:0] out_reg, out_next;
    logic [DATA_W-1:0] left_q, right_q, start_q;

    assign sts.issue_last = (k_reg == IW'(DIM - 1));
    assign sts.pipe_empty = !rd_vld_reg && !mul_vld_reg;

    imm_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_left_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (in_left),
        .rd_addr (cell_addr(32'(row_reg), 32'(k_reg))),
        .rd_data (left_q)
    );

    imm_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_right_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (in_right),
        .rd_addr (cell_addr(32'(k_reg), 32'(col_reg))),
        .rd_data (right_q)
    );

    imm_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_start_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (in_start),
        .rd_addr (cell_addr(32'(row_reg), 32'(col_reg))),
        .rd_data (start_q)
    );

    always_comb begin
        row_next    = row_reg;
        col_next    = col_reg;
        inside_next = inside_reg;
        k_next      = k_reg;
        if (cmd.start) begin
            row_next    = in_row;
            col_next    = in_col;
            inside_next = sts.req_inside;
            k_next      = '0;
        end else if (cmd.issue) begin
            k_next = sts.issue_last ? '0 : k_reg + 1'b1;
        end
    end

    // low word of the product is all that survives the wrap
    assign prod_next = left_q * right_q;

    always_comb begin
        acc_next = acc_reg;
        if (first_vld_reg) begin
            acc_next = start_q;
        end else if (mul_vld_reg) begin
            acc_next = acc_reg + prod_reg;
        end
    end

    always_comb begin
        out_next = out_reg;
        if (cmd.load_out) begin
            out_next = {{M_PAD{1'b0}}, col_reg, row_reg,
                        inside_reg ? acc_reg : {DATA_W{1'b0}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg    <= 1'b0;
            first_vld_reg <= 1'b0;
            mul_vld_reg   <= 1'b0;
        end else begin
            rd_vld_reg    <= cmd.issue;
            first_vld_reg <= cmd.issue && (k_reg == '0);
            mul_vld_reg   <= rd_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        row_reg    <= row_next;
        col_reg    <= col_next;
        inside_reg <= inside_next;
        k_reg      <= k_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        out_reg    <= out_next;
    end

    assign m_tdata = out_reg;

endmodule

### sv/imm_ctrl.sv
`include "integer_matrix_multiply_macros.svh"

module imm_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    input  logic           s_tuser,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    output imm_pkg::cmd_t  cmd,
    input  imm_pkg::sts_t  sts
);
    import imm_pkg::*;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tuser == OP_READ) begin
                    state_next = sts.req_inside ? ST_ISSUE : ST_RESULT;
                end
            end
            ST_ISSUE: begin
                if (sts.issue_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (sts.pipe_empty) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready     = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                cmd.write = s_tvalid && (s_tuser == OP_WRITE);
                cmd.start = s_tvalid && (s_tuser == OP_READ);
            end
            ST_ISSUE:  cmd.issue    = 1'b1;
            ST_DRAIN:  cmd          = '0;
            ST_RESULT: cmd.load_out = out_free;
            default:   cmd          = '0;
        endcase
    end

    // output beat holds until taken; a fresh load may replace a beat taken this cycle
    assign m_tvalid_next = cmd.load_out ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    `IMM_ASSERT_IMPL(a_load_free, aclk, aresetn, cmd.load_out, !m_tvalid_reg || m_tready)
    `IMM_ASSERT_NEXT(a_last_drains, aclk, aresetn, state_reg == ST_ISSUE && sts.issue_last, state_reg == ST_DRAIN)
    `IMM_ASSERT_NEXT(a_read_runs, aclk, aresetn, cmd.start && sts.req_inside, state_reg == ST_ISSUE)
    `IMM_ASSERT_NEXT(a_result_shown, aclk, aresetn, cmd.load_out, m_tvalid_reg)

endmodule

### sv/integer_matrix_multiply.sv
// Write beat: stored in the accept cycle, one write beat per cycle while idle (no read in progress).
// Read beat inside the matrix: one A/B pair per cycle fetched from the element RAMs, then
// pipeline drain and result load once the output register is free; outside reads load zero.
// Next beat is accepted once the result sits in the output register.
// Reset clears control only; element RAMs hold garbage until written, no clearing pass.
module integer_matrix_multiply #(
    parameter int DIM = imm_pkg::DIM_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // row, col, left_value, right_value, start_value, zero pad
    input  logic [imm_pkg::S_TDATA_W-1:0] s_tdata,
    // operation
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // product_value, out_row, out_col, zero pad
    output logic [imm_pkg::M_TDATA_W-1:0] m_tdata
);
    import imm_pkg::*;

    cmd_t cmd;
    sts_t sts;

    imm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    imm_datapath #(.DIM(DIM)) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata),
        .cmd     (cmd),
        .sts     (sts)
    );

endmodule
